// ===== hw/rtl/lppr_pkg.sv =====
// lppr_pkg: shared constants, codes and controller/datapath signal groups
// for the length-prefixed packet receiver; no dependencies
`default_nettype none

package lppr_pkg;

    // buffer size and field widths
    localparam int PACKET_MAX_BYTES = 32;
    localparam int IDX_W            = $clog2(PACKET_MAX_BYTES);
    localparam int LEN_W            = 6;
    localparam int TMO_W            = 16;
    localparam int BYTE_W           = 8;
    localparam int CMD_W            = 3;
    localparam int PADDR_W          = 4;
    localparam int PDATA_W          = 32;
    localparam int REGIDX_W         = 2;

    // input commands
    typedef enum logic [CMD_W-1:0] {
        CMD_BYTE  = 3'd0,
        CMD_TICK  = 3'd1,
        CMD_START = 3'd2,
        CMD_ABORT = 3'd3,
        CMD_TAKEN = 3'd4
    } cmd_t;

    // receiver modes, as reported in rx_state
    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_LISTEN  = 2'd1,
        MODE_RECEIVE = 2'd2
    } mode_t;

    // configuration register indexes
    localparam logic [REGIDX_W-1:0] REG_MIN_LENGTH = 2'd0;
    localparam logic [REGIDX_W-1:0] REG_MAX_LENGTH = 2'd1;
    localparam logic [REGIDX_W-1:0] REG_RX_TIMEOUT = 2'd2;

    // register reset values and fixed limits
    localparam logic [LEN_W-1:0]  MIN_LENGTH_RST = 6'd2;
    localparam logic [LEN_W-1:0]  MAX_LENGTH_RST = 6'd32;
    localparam logic [TMO_W-1:0]  RX_TIMEOUT_RST = 16'd100;
    localparam logic [BYTE_W-1:0] LENGTH_FLOOR   = 8'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic  capture;
        logic  tmo_reload;
        logic  tmo_dec;
        logic  store_first;
        logic  store_byte;
        logic  clr_index;
        logic  clr_expected;
        logic  set_ready;
        logic  clr_ready;
        logic  rd_start;
        logic  rd_issue;
        logic  rd_next;
        logic  out_status;
        logic  out_byte;
        mode_t mode;
    } lppr_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             in_range;
        logic             tmo_zero;
        logic             pkt_done;
        logic             rd_last;
        logic             out_free;
    } lppr_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lppr_ctrl.sv =====
// lppr_ctrl: sequencing state machine and receiver mode register
// depends on lppr_pkg
`default_nettype none

module lppr_ctrl (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  lppr_pkg::lppr_stat_t stat,
    output lppr_pkg::lppr_cmd_t  cmd
);
    import lppr_pkg::*;

    typedef enum logic [2:0] {
        ST_WAIT,
        ST_EXEC,
        ST_STATUS,
        ST_READ,
        ST_PUSH
    } state_t;

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;

    assign s_ready = (state_reg == ST_WAIT);

    // command decode and next state
    always_comb begin
        cmd        = '0;
        cmd.mode   = mode_reg;
        state_next = state_reg;
        mode_next  = mode_reg;
        case (state_reg)
            ST_WAIT: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_STATUS;
                case (stat.cmd)
                    CMD_BYTE: begin
                        if (mode_reg == MODE_LISTEN) begin
                            cmd.tmo_reload = 1'b1;
                            if (stat.in_range) begin
                                cmd.store_first = 1'b1;
                                mode_next       = MODE_RECEIVE;
                            end
                        end else if (mode_reg == MODE_RECEIVE) begin
                            cmd.tmo_reload = 1'b1;
                            cmd.store_byte = 1'b1;
                            if (stat.pkt_done) begin
                                cmd.set_ready = 1'b1;
                                cmd.clr_index = 1'b1;
                                cmd.rd_start  = 1'b1;
                                mode_next     = MODE_LISTEN;
                                state_next    = ST_READ;
                            end
                        end
                    end
                    CMD_TICK: begin
                        if (!stat.tmo_zero) begin
                            cmd.tmo_dec = 1'b1;
                        end else if (mode_reg == MODE_RECEIVE) begin
                            cmd.clr_index = 1'b1;
                            mode_next     = MODE_LISTEN;
                        end
                    end
                    CMD_START: begin
                        cmd.clr_index    = 1'b1;
                        cmd.clr_expected = 1'b1;
                        cmd.tmo_reload   = 1'b1;
                        mode_next        = MODE_LISTEN;
                    end
                    CMD_ABORT: begin
                        mode_next = MODE_IDLE;
                    end
                    CMD_TAKEN: begin
                        cmd.clr_ready = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            ST_STATUS: begin
                if (stat.out_free) begin
                    cmd.out_status = 1'b1;
                    state_next     = ST_WAIT;
                end
            end
            ST_READ: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_PUSH;
            end
            ST_PUSH: begin
                if (stat.out_free) begin
                    cmd.out_byte = 1'b1;
                    if (stat.rd_last) begin
                        state_next = ST_WAIT;
                    end else begin
                        cmd.rd_next = 1'b1;
                        state_next  = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_WAIT;
            end
        endcase
    end

    // state and mode registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_WAIT;
            mode_reg  <= MODE_IDLE;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

    // output register is never loaded while a new transaction is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_status || cmd.out_byte) |-> !cmd.capture)
        else $error("result load coincides with input capture");

    // a valid length byte always moves the receiver into reception
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.store_first |=> (mode_reg == MODE_RECEIVE))
        else $error("first byte stored without entering reception");

    // completing a packet always starts the buffer walk
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.set_ready |=> (state_reg == ST_READ))
        else $error("packet completed without emission");

    // the last packet byte hands the input side back
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_byte && stat.rd_last) |=> s_ready)
        else $error("input not ready after last packet byte");

endmodule

`default_nettype wire

// ===== hw/rtl/lppr_dpath.sv =====
// lppr_dpath: config registers, packet buffer, counters, flags and result register
// depends on lppr_pkg
`default_nettype none

module lppr_dpath (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  lppr_pkg::lppr_cmd_t             cmd,
    output lppr_pkg::lppr_stat_t            stat,
    input  wire [lppr_pkg::CMD_W-1:0]       s_cmd,
    input  wire [lppr_pkg::BYTE_W-1:0]      s_rx_byte,
    output logic                            m_valid,
    input  wire                             m_ready,
    output logic                            m_kind,
    output logic [lppr_pkg::BYTE_W-1:0]     m_packet_byte,
    output logic                            m_last_byte,
    output logic [1:0]                      m_rx_state,
    output logic                            m_packet_ready,
    output logic                            m_overrun_error,
    input  wire                             psel,
    input  wire                             penable,
    input  wire                             pwrite,
    input  wire [lppr_pkg::PADDR_W-1:0]     paddr,
    input  wire [lppr_pkg::PDATA_W-1:0]     pwdata,
    output logic [lppr_pkg::PDATA_W-1:0]    prdata
);
    import lppr_pkg::*;

    logic [LEN_W-1:0]   min_length_reg;
    logic [LEN_W-1:0]   max_length_reg;
    logic [TMO_W-1:0]   rx_timeout_reg;
    logic [CMD_W-1:0]   cmd_code_reg;
    logic [BYTE_W-1:0]  byte_reg;
    logic [LEN_W-1:0]   write_index_reg;
    logic [LEN_W-1:0]   expected_reg;
    logic [TMO_W-1:0]   timeout_reg;
    logic               ready_reg;
    logic               overrun_reg;
    logic [LEN_W-1:0]   rd_idx_reg;
    logic [BYTE_W-1:0]  rd_data_reg;
    logic               m_valid_reg;
    logic               kind_reg;
    logic [BYTE_W-1:0]  packet_byte_reg;
    logic               last_reg;
    logic [1:0]         rx_state_reg;
    logic               packet_ready_reg;
    logic               overrun_out_reg;
    logic [BYTE_W-1:0]  packet_store [PACKET_MAX_BYTES];

    logic [REGIDX_W-1:0] reg_idx;
    logic                cfg_write;
    logic [BYTE_W-1:0]   len_lo;
    logic [BYTE_W-1:0]   len_hi;
    logic [LEN_W:0]      wi_inc;
    logic [LEN_W:0]      rd_inc;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;

    // apb register access
    assign reg_idx   = paddr[REGIDX_W+1:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_length_reg <= MIN_LENGTH_RST;
            max_length_reg <= MAX_LENGTH_RST;
            rx_timeout_reg <= RX_TIMEOUT_RST;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_MIN_LENGTH: min_length_reg <= pwdata[LEN_W-1:0];
                REG_MAX_LENGTH: max_length_reg <= pwdata[LEN_W-1:0];
                REG_RX_TIMEOUT: rx_timeout_reg <= pwdata[TMO_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MIN_LENGTH: prdata = PDATA_W'(min_length_reg);
            REG_MAX_LENGTH: prdata = PDATA_W'(max_length_reg);
            REG_RX_TIMEOUT: prdata = PDATA_W'(rx_timeout_reg);
            default:        prdata = '0;
        endcase
    end

    // captured input transaction
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cmd_code_reg <= s_cmd;
            byte_reg     <= s_rx_byte;
        end
    end

    // length window, clamped to the buffer and floored at two
    assign len_lo = (min_length_reg < LENGTH_FLOOR[LEN_W-1:0]) ? LENGTH_FLOOR
                                                               : BYTE_W'(min_length_reg);
    assign len_hi = (BYTE_W'(max_length_reg) > BYTE_W'(PACKET_MAX_BYTES))
                  ? BYTE_W'(PACKET_MAX_BYTES) : BYTE_W'(max_length_reg);

    assign wi_inc = {1'b0, write_index_reg} + 1'b1;
    assign rd_inc = {1'b0, rd_idx_reg} + 1'b1;

    // status back to the controller
    always_comb begin
        stat.cmd      = cmd_code_reg;
        stat.in_range = (byte_reg >= len_lo) && (byte_reg <= len_hi);
        stat.tmo_zero = (timeout_reg == '0);
        stat.pkt_done = (wi_inc >= {1'b0, expected_reg});
        stat.rd_last  = (rd_inc == {1'b0, expected_reg});
        stat.out_free = !m_valid_reg || m_ready;
    end

    // write index, expected length, timeout and flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_index_reg <= '0;
            expected_reg    <= '0;
            timeout_reg     <= '0;
            ready_reg       <= 1'b0;
            overrun_reg     <= 1'b0;
        end else begin
            if (cmd.store_first) begin
                expected_reg    <= byte_reg[LEN_W-1:0];
                write_index_reg <= LEN_W'(1);
            end else if (cmd.clr_index) begin
                write_index_reg <= '0;
            end else if (cmd.store_byte) begin
                write_index_reg <= wi_inc[LEN_W-1:0];
            end
            if (cmd.clr_expected) begin
                expected_reg <= '0;
            end
            if (cmd.tmo_reload) begin
                timeout_reg <= rx_timeout_reg;
            end else if (cmd.tmo_dec) begin
                timeout_reg <= timeout_reg - 1'b1;
            end
            if (cmd.set_ready) begin
                ready_reg   <= 1'b1;
                overrun_reg <= overrun_reg | ready_reg;
            end else if (cmd.clr_ready) begin
                ready_reg <= 1'b0;
            end
        end
    end

    // packet buffer: one write port, one registered read port
    assign wr_en   = cmd.store_first ||
                     (cmd.store_byte &&
                      ({1'b0, write_index_reg} < (LEN_W+1)'(PACKET_MAX_BYTES)));
    assign wr_addr = cmd.store_first ? '0 : write_index_reg[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            packet_store[wr_addr] <= byte_reg;
        end
        if (cmd.rd_issue) begin
            rd_data_reg <= packet_store[rd_idx_reg[IDX_W-1:0]];
        end
    end

    // emission read pointer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_idx_reg <= '0;
        end else if (cmd.rd_start) begin
            rd_idx_reg <= '0;
        end else if (cmd.rd_next) begin
            rd_idx_reg <= rd_inc[LEN_W-1:0];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_status || cmd.out_byte) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_status || cmd.out_byte) begin
            kind_reg         <= cmd.out_byte;
            packet_byte_reg  <= cmd.out_byte ? rd_data_reg : '0;
            last_reg         <= cmd.out_byte && stat.rd_last;
            rx_state_reg     <= cmd.mode;
            packet_ready_reg <= ready_reg;
            overrun_out_reg  <= overrun_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_kind          = kind_reg;
    assign m_packet_byte   = packet_byte_reg;
    assign m_last_byte     = last_reg;
    assign m_rx_state      = rx_state_reg;
    assign m_packet_ready  = packet_ready_reg;
    assign m_overrun_error = overrun_out_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/length_prefixed_packet_receiver_top.sv =====
// length_prefixed_packet_receiver_top: top level joining controller and datapath
// depends on lppr_pkg, lppr_ctrl and lppr_dpath
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------------------
//  input    | s_valid / s_ready       | s_cmd, s_rx_byte
//  result   | m_valid / m_ready       | m_kind, m_packet_byte, m_last_byte,
//           |                         | m_rx_state, m_packet_ready, m_overrun_error
//  config   | psel / penable / pready | paddr, pwrite, pwdata, prdata
//
// an item that gives a status result passes through capture, execute and result load
// before the next acceptance
// a completing byte is followed by emission of the n-byte packet: each byte needs a
// registered buffer read and then a result load
// a full result register stalls the sequencer; reset is synchronous, active low
`default_nettype none

module length_prefixed_packet_receiver_top (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_valid,
    output logic                            s_ready,
    input  wire [lppr_pkg::CMD_W-1:0]       s_cmd,
    input  wire [lppr_pkg::BYTE_W-1:0]      s_rx_byte,
    output logic                            m_valid,
    input  wire                             m_ready,
    output logic                            m_kind,
    output logic [lppr_pkg::BYTE_W-1:0]     m_packet_byte,
    output logic                            m_last_byte,
    output logic [1:0]                      m_rx_state,
    output logic                            m_packet_ready,
    output logic                            m_overrun_error,
    input  wire                             psel,
    input  wire                             penable,
    input  wire                             pwrite,
    input  wire [lppr_pkg::PADDR_W-1:0]     paddr,
    input  wire [lppr_pkg::PDATA_W-1:0]     pwdata,
    output logic [lppr_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);
    import lppr_pkg::*;

    lppr_cmd_t  cmd;
    lppr_stat_t stat;

    assign pready = 1'b1;

    // sequencing and mode control
    lppr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // storage, counters and result register
    lppr_dpath u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_cmd           (s_cmd),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_packet_byte   (m_packet_byte),
        .m_last_byte     (m_last_byte),
        .m_rx_state      (m_rx_state),
        .m_packet_ready  (m_packet_ready),
        .m_overrun_error (m_overrun_error),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata)
    );

endmodule

`default_nettype wire

// ===== tb/length_prefixed_packet_receiver_top_tb.sv =====
// self-checking testbench for the length-prefixed packet receiver: directed and
// random transactions checked against an in-bench predictor of the receiver
// depends on lppr_pkg and length_prefixed_packet_receiver_top
`timescale 1ns / 100ps

module length_prefixed_packet_receiver_top_tb;

    import lppr_pkg::*;

    // worst case is roughly 455 items, each a 32-byte run with every result
    // held by the longest back-pressure gap; the limit leaves a wide margin over that
    localparam int unsigned CYCLE_LIMIT      = 2_000_000;
    localparam int unsigned SETTLE_CYCLES    = 8;
    localparam int unsigned MISMATCH_REPORTS = 10;

    // command codes the receiver does not decode
    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] packet_byte;
        logic              last_byte;
        logic [1:0]        rx_state;
        logic              packet_ready;
        logic              overrun_error;
    } rx_result_t;

    // block inputs, all known from time zero
    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic [CMD_W-1:0]   s_cmd     = '0;
    logic [BYTE_W-1:0]  s_rx_byte = '0;
    logic               m_ready   = 1'b0;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [PDATA_W-1:0] pwdata    = '0;

    // block outputs
    wire                s_ready;
    wire                m_valid;
    wire                m_kind;
    wire [BYTE_W-1:0]   m_packet_byte;
    wire                m_last_byte;
    wire [1:0]          m_rx_state;
    wire                m_packet_ready;
    wire                m_overrun_error;
    wire [PDATA_W-1:0]  prdata;
    wire                pready;

    // predicted receiver configuration and state
    logic [LEN_W-1:0]  cfg_min_length = MIN_LENGTH_RST;
    logic [LEN_W-1:0]  cfg_max_length = MAX_LENGTH_RST;
    logic [TMO_W-1:0]  cfg_rx_timeout = RX_TIMEOUT_RST;
    mode_t             pred_mode      = MODE_IDLE;
    logic [BYTE_W-1:0] pred_store [PACKET_MAX_BYTES];
    logic [LEN_W-1:0]  pred_wr_idx    = '0;
    logic [LEN_W-1:0]  pred_exp_len   = '0;
    logic [TMO_W-1:0]  pred_tmo_count = '0;
    logic              pred_ready     = 1'b0;
    logic              pred_overrun   = 1'b0;

    rx_result_t  expected_results[$];
    int unsigned failure_count = 0;
    int unsigned items_sent    = 0;
    int unsigned cycle_count   = 0;
    int unsigned stall_left    = 0;
    bit          no_idle       = 1'b0;

    length_prefixed_packet_receiver_top DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_packet_byte   (m_packet_byte),
        .m_last_byte     (m_last_byte),
        .m_rx_state      (m_rx_state),
        .m_packet_ready  (m_packet_ready),
        .m_overrun_error (m_overrun_error),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned rand_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_failure(input string what, input int unsigned want,
                                  input int unsigned got);
        failure_count++;
        if (failure_count <= MISMATCH_REPORTS)
            $display("mismatch at cycle %0d: %s expected 0x%0h got 0x%0h",
                     cycle_count, what, want, got);
    endtask

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got)
            report_failure(what, want, got);
    endtask

    function automatic rx_result_t make_result(input logic kind,
                                               input logic [BYTE_W-1:0] data,
                                               input logic last);
        rx_result_t res;
        res.kind          = kind;
        res.packet_byte   = data;
        res.last_byte     = last;
        res.rx_state      = pred_mode;
        res.packet_ready  = pred_ready;
        res.overrun_error = pred_overrun;
        return res;
    endfunction

    // receiver behaviour for one accepted transaction; queues its results
    task automatic predict_receiver_step(input logic [CMD_W-1:0] cmd,
                                         input logic [BYTE_W-1:0] rx_byte);
        logic [BYTE_W-1:0] lo;
        logic [BYTE_W-1:0] hi;
        logic              done;
        int unsigned       n;
        done = 1'b0;
        case (cmd)
            CMD_BYTE: begin
                if (pred_mode == MODE_LISTEN) begin
                    lo = (cfg_min_length < LENGTH_FLOOR) ? LENGTH_FLOOR
                                                         : {2'b00, cfg_min_length};
                    hi = (cfg_max_length > PACKET_MAX_BYTES) ? BYTE_W'(PACKET_MAX_BYTES)
                                                             : {2'b00, cfg_max_length};
                    pred_tmo_count = cfg_rx_timeout;
                    if (rx_byte >= lo && rx_byte <= hi) begin
                        pred_store[0] = rx_byte;
                        pred_exp_len  = rx_byte[LEN_W-1:0];
                        pred_wr_idx   = LEN_W'(1);
                        pred_mode     = MODE_RECEIVE;
                    end
                end else if (pred_mode == MODE_RECEIVE) begin
                    pred_tmo_count = cfg_rx_timeout;
                    if (pred_wr_idx < PACKET_MAX_BYTES)
                        pred_store[pred_wr_idx] = rx_byte;
                    pred_wr_idx = pred_wr_idx + 1'b1;
                    if (pred_wr_idx >= pred_exp_len) begin
                        if (pred_ready)
                            pred_overrun = 1'b1;
                        pred_ready  = 1'b1;
                        pred_mode   = MODE_LISTEN;
                        pred_wr_idx = '0;
                        done        = 1'b1;
                    end
                end
            end
            CMD_TICK: begin
                if (pred_tmo_count != 0) begin
                    pred_tmo_count = pred_tmo_count - 1'b1;
                end else if (pred_mode == MODE_RECEIVE) begin
                    pred_mode   = MODE_LISTEN;
                    pred_wr_idx = '0;
                end
            end
            CMD_START: begin
                pred_mode      = MODE_LISTEN;
                pred_wr_idx    = '0;
                pred_exp_len   = '0;
                pred_tmo_count = cfg_rx_timeout;
            end
            CMD_ABORT: begin
                pred_mode = MODE_IDLE;
            end
            CMD_TAKEN: begin
                pred_ready = 1'b0;
            end
            default: begin
            end
        endcase

        if (done) begin
            n = (pred_exp_len > PACKET_MAX_BYTES) ? PACKET_MAX_BYTES : pred_exp_len;
            for (int unsigned i = 0; i < n; i++)
                expected_results.push_back(make_result(1'b1, pred_store[i], i + 1 == n));
        end else begin
            expected_results.push_back(make_result(1'b0, '0, 1'b0));
        end
    endtask

    // result channel back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (no_idle || $urandom_range(0, 1)) begin
            m_ready    <= 1'b1;
            stall_left <= $urandom_range(0, 6);
        end else begin
            m_ready    <= 1'b0;
            stall_left <= rand_gap();
        end
    end

    // result checker: every transaction against the oldest expectation
    always @(posedge aclk) begin
        rx_result_t got;
        rx_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_kind, m_packet_byte, m_last_byte, m_rx_state,
                   m_packet_ready, m_overrun_error};
            if (expected_results.size() == 0) begin
                report_failure("result with nothing expected", 0, got);
            end else begin
                want = expected_results.pop_front();
                check_field("kind", want.kind, got.kind);
                check_field("packet_byte", want.packet_byte, got.packet_byte);
                check_field("last_byte", want.last_byte, got.last_byte);
                check_field("rx_state", want.rx_state, got.rx_state);
                check_field("packet_ready", want.packet_ready, got.packet_ready);
                check_field("overrun_error", want.overrun_error, got.overrun_error);
            end
        end
    end

    // one input transaction, with an optional idle gap ahead of it
    task automatic send_rx_item(input logic [CMD_W-1:0] cmd,
                                input logic [BYTE_W-1:0] rx_byte);
        int unsigned gap;
        gap = no_idle ? 0 : rand_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_cmd     <= cmd;
        s_rx_byte <= rx_byte;
        do @(posedge aclk); while (!s_ready);
        predict_receiver_step(cmd, rx_byte);
        items_sent++;
    endtask

    // hold the sender off until every expected result is in
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // register write followed by a read-back, with the bus returned to idle
    task automatic write_register(input logic [REGIDX_W-1:0] idx,
                                  input logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] stored;
        logic [PDATA_W-1:0] readback;
        case (idx)
            REG_MIN_LENGTH: stored = PDATA_W'(value[LEN_W-1:0]);
            REG_MAX_LENGTH: stored = PDATA_W'(value[LEN_W-1:0]);
            default:        stored = PDATA_W'(value[TMO_W-1:0]);
        endcase

        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_MIN_LENGTH: cfg_min_length = value[LEN_W-1:0];
            REG_MAX_LENGTH: cfg_max_length = value[LEN_W-1:0];
            default:        cfg_rx_timeout = value[TMO_W-1:0];
        endcase

        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        check_field("register read-back", stored, readback);
    endtask

    task automatic configure_receiver(input int unsigned min_len, input int unsigned max_len,
                                      input int unsigned timeout_ticks);
        wait_results_drained();
        write_register(REG_MIN_LENGTH, min_len);
        write_register(REG_MAX_LENGTH, max_len);
        write_register(REG_RX_TIMEOUT, timeout_ticks);
    endtask

    task automatic send_tick_burst();
        repeat ($urandom_range(1, 4)) send_rx_item(CMD_TICK, 8'($urandom));
    endtask

    // a mostly well-formed packet with random content, sometimes broken up
    task automatic send_random_packet();
        int unsigned lo;
        int unsigned hi;
        int unsigned len;
        int unsigned r;
        lo = (cfg_min_length < LENGTH_FLOOR) ? LENGTH_FLOOR : cfg_min_length;
        hi = (cfg_max_length > PACKET_MAX_BYTES) ? PACKET_MAX_BYTES : cfg_max_length;
        if (pred_mode != MODE_LISTEN)
            send_rx_item(CMD_START, 8'($urandom));
        if (lo > hi)
            len = $urandom_range(LENGTH_FLOOR, PACKET_MAX_BYTES);
        else if ($urandom_range(0, 99) < 85)
            len = $urandom_range(lo, (hi < lo + 6) ? hi : lo + 6);
        else
            len = $urandom_range(lo, hi);
        send_rx_item(CMD_BYTE, len[BYTE_W-1:0]);
        for (int unsigned i = 1; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                send_tick_burst();
            end else if (r < 10) begin
                send_rx_item($urandom_range(0, 1) ? CMD_START : CMD_ABORT, 8'($urandom));
                return;
            end
            send_rx_item(CMD_BYTE, 8'($urandom));
        end
        if ($urandom_range(0, 99) < 70)
            send_rx_item(CMD_TAKEN, 8'($urandom));
    endtask

    // commands in idle mode, including undecoded ones
    task automatic test_idle_commands();
        send_rx_item(CMD_BYTE, 8'hFF);
        send_rx_item(CMD_TICK, 8'h00);
        send_rx_item(CMD_TAKEN, 8'h00);
        send_rx_item(CMD_SPARE_FIRST, 8'h5A);
        send_rx_item(CMD_SPARE_LAST, 8'hA5);
        send_rx_item(CMD_ABORT, 8'h00);
    endtask

    // length byte below the floor, zero, above the range, then the shortest packet
    task automatic test_length_limits();
        send_rx_item(CMD_START, 8'h00);
        send_rx_item(CMD_BYTE, 8'd1);
        send_rx_item(CMD_BYTE, 8'd0);
        send_rx_item(CMD_BYTE, 8'd33);
        send_rx_item(CMD_BYTE, 8'd2);
        send_rx_item(CMD_BYTE, 8'hAA);
    endtask

    // second packet while the first is unconsumed, then the consumer takes it
    task automatic test_overrun();
        send_rx_item(CMD_BYTE, 8'd3);
        send_rx_item(CMD_BYTE, 8'h00);
        send_rx_item(CMD_BYTE, 8'hFF);
        send_rx_item(CMD_TAKEN, 8'h00);
    endtask

    // partial packet lost on abort, byte ignored while idle, tick while listening
    task automatic test_abort_partial();
        send_rx_item(CMD_START, 8'h00);
        send_rx_item(CMD_BYTE, 8'd4);
        send_rx_item(CMD_BYTE, 8'h11);
        send_rx_item(CMD_ABORT, 8'h00);
        send_rx_item(CMD_BYTE, 8'h22);
        send_rx_item(CMD_START, 8'h00);
        send_rx_item(CMD_TICK, 8'h00);
    endtask

    // zero minimum, clamped maximum, zero timeout; then minimum above maximum
    task automatic test_register_extremes();
        configure_receiver(0, 63, 0);
        send_rx_item(CMD_START, 8'h00);
        send_rx_item(CMD_BYTE, 8'd1);
        send_rx_item(CMD_BYTE, 8'd33);
        send_rx_item(CMD_BYTE, 8'd2);
        send_rx_item(CMD_TICK, 8'h00);
        configure_receiver(10, 5, 65535);
        send_rx_item(CMD_START, 8'h00);
        send_rx_item(CMD_BYTE, 8'd7);
    endtask

    // random mix, mostly packets, with ticks, control commands and noise
    task automatic test_random_traffic(input int unsigned item_budget);
        int unsigned stop_at;
        int unsigned r;
        stop_at = items_sent + item_budget;
        while (items_sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 62)
                send_random_packet();
            else if (r < 72)
                send_tick_burst();
            else if (r < 79)
                send_rx_item(CMD_TAKEN, 8'($urandom));
            else if (r < 84)
                send_rx_item(CMD_START, 8'($urandom));
            else if (r < 88)
                send_rx_item(CMD_ABORT, 8'($urandom));
            else if (r < 94)
                send_rx_item(CMD_BYTE, 8'($urandom));
            else
                send_rx_item(3'($urandom_range(CMD_TAKEN, CMD_SPARE_LAST)), 8'($urandom));
        end
    endtask

    // test sequence
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_idle_commands();
        test_length_limits();
        test_overrun();
        test_abort_partial();
        test_register_extremes();

        configure_receiver(MIN_LENGTH_RST, MAX_LENGTH_RST, RX_TIMEOUT_RST);
        test_random_traffic(110);

        no_idle = 1'b1;
        configure_receiver(2, 5, 2);
        test_random_traffic(100);
        no_idle = 1'b0;

        configure_receiver($urandom_range(0, 12), $urandom_range(0, 63),
                           $urandom_range(0, 4));
        test_random_traffic(110);

        configure_receiver(30, 63, 65535);
        test_random_traffic(60);

        configure_receiver(0, 0, 0);
        test_random_traffic(30);

        wait_results_drained();
        if (failure_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
